>>> hw/rtl/ptmt_pkg.sv
package ptmt_pkg;

  localparam int RING_DEPTH = 16;
  localparam int BUNDLE = 8;
  localparam int NODE_COUNT = 8;
  localparam int DIFFS_PER_NODE = 4;

  localparam int RING_AW = $clog2(RING_DEPTH);
  localparam int NODE_AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int DIFF_AW = $clog2(DIFFS_PER_NODE);
  localparam int DIFF_DEPTH = 2 ** (NODE_AW + DIFF_AW);
  localparam int BUNDLE_OFS = BUNDLE % RING_DEPTH;
  localparam int CNT_W = $clog2(RING_DEPTH + NODE_COUNT + DIFFS_PER_NODE + 1) + 1;

  localparam int RING_W = 48 + 16 + 64;
  localparam int DIFF_W = 64 + 32 + 64;

  localparam logic [1:0] OP_FRAME = 2'd0;
  localparam logic [1:0] OP_RECORD = 2'd1;
  localparam logic [1:0] OP_BUNDLE = 2'd2;

  localparam logic [3:0] ST_STORED = 4'd0;
  localparam logic [3:0] ST_FILTERED = 4'd1;
  localparam logic [3:0] ST_ZERO_HANDLE = 4'd2;
  localparam logic [3:0] ST_NOT_BUFFERED = 4'd3;
  localparam logic [3:0] ST_DIFF_STORED = 4'd4;
  localparam logic [3:0] ST_DUPLICATE = 4'd5;
  localparam logic [3:0] ST_TABLE_FULL = 4'd6;
  localparam logic [3:0] ST_RECORD = 4'd7;
  localparam logic [3:0] ST_EMPTY = 4'd8;

  function automatic logic [31:0] make_handle(logic [15:0] seq, logic [47:0] mac);
    make_handle = {mac[7:0], mac[15:8], seq};
  endfunction

endpackage

>>> hw/rtl/packet_timestamp_match_table.sv
// Timestamp match table for observed wireless frames.
// A command beat is taken at a rising edge where start is high and busy is
// low. Opcode 0 records a local frame in the ring, opcode 1 matches a
// neighbor's sync record and stores the time difference, opcode 2 returns
// the valid ring entries of the recent bundle window, oldest first.
// Each result beat is shown for exactly one cycle with done high; last marks
// the final beat of a command. The receiver cannot stall the block.
// Per command: a filtered frame or a zero handle answers in the cycle after
// the command is taken. A stored frame takes one pass over the ring memory,
// one slot a cycle. A sync record takes up to a ring pass, a node memory
// pass and a diff memory pass. A bundle takes one pass over its window of
// the ring, its result beats spread over that pass. busy stays high until
// the last beat is issued; the next command may be accepted in the cycle of
// that beat. Reset clears the valid and index bits, the node table and the
// pointers, so every entry reads as empty; no clearing pass is needed.
module packet_timestamp_match_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic        frame_is_tx,
  input  logic        frame_rx_error,
  input  logic        frame_retry,
  input  logic [1:0]  frame_direction,
  input  logic [47:0] addr_two,
  input  logic [47:0] addr_three,
  input  logic [15:0] seq_field,
  input  logic [63:0] driver_time,
  input  logic [63:0] fallback_time,
  input  logic [63:0] now_time,
  input  logic [3:0]  max_records,
  output logic        done,
  output logic [3:0]  status,
  output logic [47:0] out_src,
  output logic [15:0] out_seq,
  output logic [63:0] out_time,
  output logic [63:0] time_difference,
  output logic        last
);

  localparam int RAW = ptmt_pkg::RING_AW;
  localparam int NAW = ptmt_pkg::NODE_AW;
  localparam int DAW = ptmt_pkg::DIFF_AW;
  localparam int CW = ptmt_pkg::CNT_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FOLD = 4'd1;
  localparam logic [3:0] S_FSCAN = 4'd2;
  localparam logic [3:0] S_RSCAN = 4'd3;
  localparam logic [3:0] S_NSCAN = 4'd4;
  localparam logic [3:0] S_DSCAN = 4'd5;
  localparam logic [3:0] S_DWR = 4'd6;
  localparam logic [3:0] S_BSCAN = 4'd7;

  logic [3:0] state;
  logic [CW-1:0] cnt;
  logic pend;
  logic [CW-1:0] pidx;

  logic [RAW-1:0] write_slot;
  logic [ptmt_pkg::RING_DEPTH-1:0] ring_written;
  logic [ptmt_pkg::RING_DEPTH-1:0] ring_indexed;
  logic [ptmt_pkg::NODE_COUNT-1:0] node_used;
  logic [DAW-1:0] diff_slot [ptmt_pkg::NODE_COUNT];
  logic [ptmt_pkg::DIFF_DEPTH-1:0] diff_valid;

  logic [47:0] src;
  logic [15:0] seq;
  logic [63:0] tval;
  logic [63:0] now;
  logic [31:0] hnew;
  logic [31:0] hold;
  logic [63:0] match_time;
  logic [NAW-1:0] node;
  logic [RAW-1:0] bidx;
  logic [3:0] remaining;
  logic held;
  logic [47:0] held_src;
  logic [15:0] held_seq;
  logic [63:0] held_time;

  logic ring_we;
  logic [RAW-1:0] ring_raddr;
  logic [ptmt_pkg::RING_W-1:0] ring_rdata;
  logic node_we;
  logic [NAW-1:0] node_waddr;
  logic [47:0] node_rdata;
  logic diff_we;
  logic [NAW+DAW-1:0] diff_waddr;
  logic [NAW+DAW-1:0] diff_raddr;
  logic [ptmt_pkg::DIFF_W-1:0] diff_rdata;
  logic [63:0] diff_d;

  logic [47:0] rd_src;
  logic [15:0] rd_seq;
  logic [31:0] rd_handle;
  logic [31:0] in_handle;
  logic node_free;
  logic [NAW-1:0] free_node;
  logic [NAW+DAW-1:0] pdiff;
  logic [3:0] cap;

  assign busy = (state != S_IDLE);
  assign rd_src = ring_rdata[127:80];
  assign rd_seq = ring_rdata[79:64];
  assign rd_handle = ptmt_pkg::make_handle(rd_seq, rd_src);
  assign in_handle = ptmt_pkg::make_handle(seq_field, addr_two);
  assign diff_d = (match_time >= tval) ? match_time - tval : tval - match_time;
  assign pdiff = {node, pidx[DAW-1:0]};
  assign cap = (32'(max_records) > ptmt_pkg::BUNDLE) ? 4'(ptmt_pkg::BUNDLE) : max_records;

  always_comb begin
    node_free = 1'b0;
    free_node = '0;
    for (int i = ptmt_pkg::NODE_COUNT - 1; i >= 0; i--) begin
      if (!node_used[i]) begin
        node_free = 1'b1;
        free_node = NAW'(i);
      end
    end
  end

  always_comb begin
    case (state)
      S_FSCAN, S_RSCAN: ring_raddr = cnt[RAW-1:0];
      S_BSCAN: ring_raddr = bidx;
      default: ring_raddr = write_slot;
    endcase
    ring_we = (state == S_FSCAN) && (cnt == CW'(ptmt_pkg::RING_DEPTH)) && !pend;
    node_we = (state == S_NSCAN) && (cnt == CW'(ptmt_pkg::NODE_COUNT)) && !pend
      && node_free;
    node_waddr = free_node;
    diff_raddr = {node, cnt[DAW-1:0]};
    diff_we = (state == S_DWR);
    diff_waddr = {node, diff_slot[node]};
  end

  ptmt_ram #(.WIDTH(ptmt_pkg::RING_W), .DEPTH(ptmt_pkg::RING_DEPTH)) u_ring (
    .clk(clk), .we(ring_we), .waddr(write_slot), .wdata({src, seq, tval}),
    .raddr(ring_raddr), .rdata(ring_rdata)
  );

  ptmt_ram #(.WIDTH(48), .DEPTH(2 ** NAW)) u_node (
    .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(src),
    .raddr(cnt[NAW-1:0]), .rdata(node_rdata)
  );

  ptmt_ram #(.WIDTH(ptmt_pkg::DIFF_W), .DEPTH(ptmt_pkg::DIFF_DEPTH)) u_diff (
    .clk(clk), .we(diff_we), .waddr(diff_waddr), .wdata({diff_d, hnew, now}),
    .raddr(diff_raddr), .rdata(diff_rdata)
  );

  always_ff @(posedge clk) begin
    done <= 1'b0;
    status <= ptmt_pkg::ST_STORED;
    out_src <= '0;
    out_seq <= '0;
    out_time <= '0;
    time_difference <= '0;
    last <= 1'b1;
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      pend <= 1'b0;
      write_slot <= '0;
      ring_written <= '0;
      ring_indexed <= '0;
      node_used <= '0;
      diff_valid <= '0;
      held <= 1'b0;
      for (int i = 0; i < ptmt_pkg::NODE_COUNT; i++) begin
        diff_slot[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          cnt <= '0;
          pend <= 1'b0;
          held <= 1'b0;
          src <= (frame_direction == 2'd2) ? addr_three : addr_two;
          seq <= seq_field;
          now <= now_time;
          if (start) begin
            case (opcode)
              ptmt_pkg::OP_FRAME: begin
                tval <= (driver_time != 64'd0) ? driver_time : fallback_time;
                hnew <= ptmt_pkg::make_handle(seq_field,
                  (frame_direction == 2'd2) ? addr_three : addr_two);
                if (frame_is_tx || frame_rx_error || frame_retry) begin
                  done <= 1'b1;
                  status <= ptmt_pkg::ST_FILTERED;
                end else begin
                  state <= S_FOLD;
                end
              end
              ptmt_pkg::OP_RECORD: begin
                src <= addr_two;
                tval <= driver_time;
                hnew <= in_handle;
                if (in_handle == 32'd0) begin
                  done <= 1'b1;
                  status <= ptmt_pkg::ST_ZERO_HANDLE;
                end else begin
                  state <= S_RSCAN;
                end
              end
              ptmt_pkg::OP_BUNDLE: begin
                remaining <= cap;
                bidx <= (32'(write_slot) >= ptmt_pkg::BUNDLE_OFS)
                  ? RAW'(32'(write_slot) - ptmt_pkg::BUNDLE_OFS)
                  : RAW'(32'(write_slot) + ptmt_pkg::RING_DEPTH - ptmt_pkg::BUNDLE_OFS);
                state <= S_BSCAN;
              end
              default: begin
                done <= 1'b1;
                status <= ptmt_pkg::ST_FILTERED;
              end
            endcase
          end
        end
        S_FOLD: begin
          hold <= ring_written[write_slot] ? rd_handle : 32'd0;
          state <= S_FSCAN;
        end
        S_FSCAN: begin
          if (cnt < CW'(ptmt_pkg::RING_DEPTH)) begin
            cnt <= cnt + 1'b1;
          end
          pend <= (cnt < CW'(ptmt_pkg::RING_DEPTH));
          pidx <= cnt;
          if (pend && (pidx[RAW-1:0] != write_slot)
              && (((hold != 32'd0) && (rd_handle == hold)) || (rd_handle == hnew))) begin
            ring_indexed[pidx[RAW-1:0]] <= 1'b0;
          end
          if (cnt == CW'(ptmt_pkg::RING_DEPTH) && !pend) begin
            ring_written[write_slot] <= 1'b1;
            ring_indexed[write_slot] <= 1'b1;
            write_slot <= (32'(write_slot) == ptmt_pkg::RING_DEPTH - 1) ? '0
              : write_slot + 1'b1;
            done <= 1'b1;
            status <= ptmt_pkg::ST_STORED;
            state <= S_IDLE;
          end
        end
        S_RSCAN: begin
          if (cnt < CW'(ptmt_pkg::RING_DEPTH)) begin
            cnt <= cnt + 1'b1;
          end
          pend <= (cnt < CW'(ptmt_pkg::RING_DEPTH));
          pidx <= cnt;
          if (pend && ring_indexed[pidx[RAW-1:0]] && (rd_handle == hnew)) begin
            match_time <= ring_rdata[63:0];
            cnt <= '0;
            pend <= 1'b0;
            state <= S_NSCAN;
          end else if (cnt == CW'(ptmt_pkg::RING_DEPTH) && !pend) begin
            done <= 1'b1;
            status <= ptmt_pkg::ST_NOT_BUFFERED;
            state <= S_IDLE;
          end
        end
        S_NSCAN: begin
          if (cnt < CW'(ptmt_pkg::NODE_COUNT)) begin
            cnt <= cnt + 1'b1;
          end
          pend <= (cnt < CW'(ptmt_pkg::NODE_COUNT));
          pidx <= cnt;
          if (pend && node_used[pidx[NAW-1:0]] && (node_rdata == src)) begin
            node <= pidx[NAW-1:0];
            cnt <= '0;
            pend <= 1'b0;
            state <= S_DSCAN;
          end else if (cnt == CW'(ptmt_pkg::NODE_COUNT) && !pend) begin
            if (!node_free) begin
              done <= 1'b1;
              status <= ptmt_pkg::ST_TABLE_FULL;
              state <= S_IDLE;
            end else begin
              node <= free_node;
              node_used[free_node] <= 1'b1;
              diff_slot[free_node] <= '0;
              for (int k = 0; k < ptmt_pkg::DIFFS_PER_NODE; k++) begin
                diff_valid[{free_node, DAW'(k)}] <= 1'b0;
              end
              state <= S_DWR;
            end
          end
        end
        S_DSCAN: begin
          if (cnt < CW'(ptmt_pkg::DIFFS_PER_NODE)) begin
            cnt <= cnt + 1'b1;
          end
          pend <= (cnt < CW'(ptmt_pkg::DIFFS_PER_NODE));
          pidx <= cnt;
          if (pend && diff_valid[pdiff] && (diff_rdata[95:64] == hnew)) begin
            done <= 1'b1;
            status <= ptmt_pkg::ST_DUPLICATE;
            state <= S_IDLE;
          end else if (cnt == CW'(ptmt_pkg::DIFFS_PER_NODE) && !pend) begin
            state <= S_DWR;
          end
        end
        S_DWR: begin
          diff_valid[diff_waddr] <= 1'b1;
          diff_slot[node] <= (32'(diff_slot[node]) == ptmt_pkg::DIFFS_PER_NODE - 1) ? '0
            : diff_slot[node] + 1'b1;
          done <= 1'b1;
          status <= ptmt_pkg::ST_DIFF_STORED;
          time_difference <= diff_d;
          state <= S_IDLE;
        end
        S_BSCAN: begin
          if (cnt < CW'(ptmt_pkg::BUNDLE_OFS)) begin
            cnt <= cnt + 1'b1;
            bidx <= (32'(bidx) == ptmt_pkg::RING_DEPTH - 1) ? '0 : bidx + 1'b1;
          end
          pend <= (cnt < CW'(ptmt_pkg::BUNDLE_OFS));
          pidx <= cnt;
          if (pend && ring_written[(32'(bidx) == 0) ? RAW'(ptmt_pkg::RING_DEPTH - 1)
              : bidx - 1'b1] && (rd_handle != 32'd0) && (remaining != 4'd0)) begin
            remaining <= remaining - 1'b1;
            held <= 1'b1;
            held_src <= rd_src;
            held_seq <= rd_seq;
            held_time <= ring_rdata[63:0];
            if (held) begin
              done <= 1'b1;
              status <= ptmt_pkg::ST_RECORD;
              out_src <= held_src;
              out_seq <= held_seq;
              out_time <= held_time;
              last <= 1'b0;
            end
          end
          if (cnt == CW'(ptmt_pkg::BUNDLE_OFS) && !pend) begin
            done <= 1'b1;
            if (held) begin
              status <= ptmt_pkg::ST_RECORD;
              out_src <= held_src;
              out_seq <= held_seq;
              out_time <= held_time;
            end else begin
              status <= ptmt_pkg::ST_EMPTY;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/ptmt_ram.sv
module ptmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
